/* rtl/core/mabsg_pkg.sv */
// Shared constants and types of the multi-axis Bresenham step generator.
package mabsg_pkg;

  // Axis count of the build, and the widths that follow from it.
  localparam int AXES   = 8;
  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int CNT_W  = $clog2(AXES + 1);

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 3;
  localparam int STEPS_W  = 31;
  localparam int ACC_W    = 32;
  localparam int LANE_W   = 8;
  localparam int STAT_W   = 3;
  localparam int SLOT_W   = 3;
  localparam int ACNT_W   = 4;
  localparam int MAP_W    = 24;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 24;
  localparam int DATA_W   = 56;

  // Reset values of the configuration registers.
  localparam logic [ACNT_W-1:0] AXIS_COUNT_RST = 4'd8;
  localparam logic [MAP_W-1:0]  PIN_MAP_RST    = 24'hFAC688;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] REG_AXIS_COUNT = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_MIN_ENABLE = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_MAX_ENABLE = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_PIN_MAP    = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_TICK = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_REJECT   = 3'd1,
    ST_FINISHED = 3'd2,
    ST_FAULT    = 3'd3,
    ST_IDLE     = 3'd4
  } status_t;

endpackage

/* rtl/core/multi_axis_bresenham_step_generator.sv */
// Top level of the multi-axis Bresenham step generator.
//
//   Channel   Direction  Handshake             Payload
//   in_*      input      in_tvalid/in_tready    tuser command, tlast final load, tdata fields
//   out_*     output     out_tvalid/out_tready  tdata result fields
//   cfg_*     input      cfg_we                 cfg_addr register index, cfg_wdata value
//
// Every input word yields exactly one result word. A stop, a rejected load, a
// load that is not the final one or a tick while idle passes from the idle
// state through the final state to the output register. An accepted final load
// or a tick in motion first sweeps the per-axis memories of the axes in use one
// axis per cycle, a rate set by the single read port of each memory; its result
// then passes through the final state to the output register. No new word is
// taken before the block is back in the idle state. A limit fault cuts the
// sweep short at the faulting axis. Reset is synchronous and active low and
// needs no clearing pass: per-axis valid bits stand in for the zeroed memory
// contents. A stalled output holds the block in its final state until the
// result register is free.
module multi_axis_bresenham_step_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: axis_index, axis_steps, axis_positive, min_limit_active,
  // max_limit_active
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mabsg_pkg::DATA_W-1:0]     in_tdata,
  input  logic [mabsg_pkg::CMD_W-1:0]      in_tuser,   // command
  input  logic                             in_tlast,   // load_last
  // out_tdata: status, step_mask, dir_mask, busy_res, steps_done
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mabsg_pkg::DATA_W-1:0]     out_tdata,
  input  logic                             cfg_we,
  input  logic [mabsg_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [mabsg_pkg::CFG_D_W-1:0]    cfg_wdata
);

  import mabsg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LSCAN = 4'b0010,
    S_TICK  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  // Configuration registers.
  logic [ACNT_W-1:0]  axis_count_r;
  logic [LANE_W-1:0]  min_en_r;
  logic [LANE_W-1:0]  max_en_r;
  logic [MAP_W-1:0]   pin_map_r;

  // Move state.
  state_t             state_r, state_nxt;
  logic               moving_r, moving_nxt;
  logic [LANE_W-1:0]  dirs_r, dirs_nxt;
  logic [STEPS_W-1:0] dom_r, dom_nxt;
  logic [STEPS_W-1:0] tick_r, tick_nxt;
  logic [AXES-1:0]    steps_vld_r, steps_vld_nxt;
  logic [AXES-1:0]    acc_vld_r, acc_vld_nxt;

  // The word being worked on.
  cmd_t               cmd_r, cmd_nxt;
  logic [LANE_W-1:0]  tick_dirs_r, tick_dirs_nxt;
  logic [LANE_W-1:0]  min_act_r, min_act_nxt;
  logic [LANE_W-1:0]  max_act_r, max_act_nxt;
  status_t            status_r, status_nxt;
  logic [LANE_W-1:0]  mask_r, mask_nxt;
  logic               fault_r, fault_nxt;
  logic [STEPS_W-1:0] scan_max_r, scan_max_nxt;

  // Sweep over the axes: read issue counter and the stage that sees read data.
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               p_vld_r, p_vld_nxt;
  logic [AXIS_W-1:0]  p_idx_r, p_idx_nxt;

  // Per-axis memories.
  logic [STEPS_W-1:0] steps_mem [AXES];
  logic [ACC_W-1:0]   acc_mem [AXES];
  logic [STEPS_W-1:0] steps_q;
  logic [ACC_W-1:0]   acc_q;
  logic               sm_we;
  logic               am_we;
  logic [ACC_W-1:0]   am_wdata;
  logic [AXIS_W-1:0]  rd_addr;

  // Result register.
  logic               out_vld_r, out_vld_nxt;
  status_t            o_status_r, o_status_nxt;
  logic [LANE_W-1:0]  o_mask_r, o_mask_nxt;
  logic [LANE_W-1:0]  o_dir_r, o_dir_nxt;
  logic               o_busy_r, o_busy_nxt;
  logic [STEPS_W-1:0] o_steps_r, o_steps_nxt;

  // Input fields.
  cmd_t               in_cmd;
  logic [IDX_W-1:0]   in_axis;
  logic [STEPS_W-1:0] in_steps;
  logic               in_pos;
  logic [LANE_W-1:0]  in_min_act;
  logic [LANE_W-1:0]  in_max_act;

  logic [CNT_W-1:0]   n_use;
  logic               issue;
  logic [STEPS_W-1:0] p_steps;
  logic [ACC_W-1:0]   p_acc;
  logic [ACC_W-1:0]   p_sum;
  logic [ACC_W:0]     p_diff;
  logic               p_ge;
  logic               p_block;
  logic [SLOT_W-1:0]  p_slot;
  logic [STEPS_W-1:0] tick_inc;

  assign in_cmd     = cmd_t'(in_tuser);
  assign in_axis    = in_tdata[2:0];
  assign in_steps   = in_tdata[33:3];
  assign in_pos     = in_tdata[34];
  assign in_min_act = in_tdata[42:35];
  assign in_max_act = in_tdata[50:43];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, o_steps_r, o_busy_r, o_dir_r, o_mask_r, o_status_r};

  // Axes in use: the register, clipped to the build's axis count.
  assign n_use = (axis_count_r > ACNT_W'(AXES)) ? CNT_W'(AXES) : CNT_W'(axis_count_r);

  // A read is issued for the next axis until all axes in use are covered or
  // a limit fault has ended the tick.
  assign issue   = (cnt_r < n_use) && !fault_r;
  assign rd_addr = cnt_r[AXIS_W-1:0];

  // Entries whose valid bit is clear read as zero.
  assign p_steps = steps_vld_r[p_idx_r] ? steps_q : '0;
  assign p_acc   = acc_vld_r[p_idx_r] ? acc_q : '0;

  // The sum wraps at 32 bits, as the accumulator does, and at most one
  // dominant count is taken off per tick.
  assign p_sum   = p_acc + ACC_W'(p_steps);
  assign p_diff  = {1'b0, p_sum} - (ACC_W + 1)'(dom_r);
  assign p_ge    = !p_diff[ACC_W];
  assign p_block = dirs_r[p_idx_r] ? (max_en_r[p_idx_r] & max_act_r[p_idx_r])
                                   : (min_en_r[p_idx_r] & min_act_r[p_idx_r]);
  assign p_slot  = pin_map_r[SLOT_W*p_idx_r +: SLOT_W];
  assign tick_inc = tick_r + STEPS_W'(1);

  always_comb begin
    state_nxt     = state_r;
    moving_nxt    = moving_r;
    dirs_nxt      = dirs_r;
    dom_nxt       = dom_r;
    tick_nxt      = tick_r;
    steps_vld_nxt = steps_vld_r;
    acc_vld_nxt   = acc_vld_r;
    cmd_nxt       = cmd_r;
    tick_dirs_nxt = tick_dirs_r;
    min_act_nxt   = min_act_r;
    max_act_nxt   = max_act_r;
    status_nxt    = status_r;
    mask_nxt      = mask_r;
    fault_nxt     = fault_r;
    scan_max_nxt  = scan_max_r;
    cnt_nxt       = cnt_r;
    p_vld_nxt     = 1'b0;
    p_idx_nxt     = p_idx_r;
    sm_we         = 1'b0;
    am_we         = 1'b0;
    am_wdata      = p_sum;
    out_vld_nxt   = out_vld_r && !out_tready;
    o_status_nxt  = o_status_r;
    o_mask_nxt    = o_mask_r;
    o_dir_nxt     = o_dir_r;
    o_busy_nxt    = o_busy_r;
    o_steps_nxt   = o_steps_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt       = in_cmd;
          tick_dirs_nxt = dirs_r;
          min_act_nxt   = in_min_act;
          max_act_nxt   = in_max_act;
          mask_nxt      = '0;
          fault_nxt     = 1'b0;
          scan_max_nxt  = '0;
          cnt_nxt       = '0;
          status_nxt    = ST_OK;
          state_nxt     = S_FIN;
          unique case (in_cmd)
            CMD_LOAD: begin
              if (moving_r || (CNT_W'(in_axis) >= n_use)) begin
                status_nxt = ST_REJECT;
              end else begin
                sm_we = 1'b1;
                steps_vld_nxt[in_axis[AXIS_W-1:0]] = 1'b1;
                dirs_nxt[in_axis] = in_pos;
                if (in_tlast) begin
                  state_nxt = S_LSCAN;
                end
              end
            end
            CMD_TICK: begin
              if (!moving_r) begin
                status_nxt = ST_IDLE;
              end else if (tick_r >= dom_r) begin
                steps_vld_nxt = '0;
                dirs_nxt      = '0;
                dom_nxt       = '0;
                moving_nxt    = 1'b0;
                status_nxt    = ST_FINISHED;
              end else begin
                state_nxt = S_TICK;
              end
            end
            CMD_STOP: begin
              steps_vld_nxt = '0;
              dirs_nxt      = '0;
              dom_nxt       = '0;
              moving_nxt    = 1'b0;
            end
            default: begin
              status_nxt = ST_REJECT;
            end
          endcase
        end
      end

      S_LSCAN: begin
        p_vld_nxt = issue;
        p_idx_nxt = rd_addr;
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (p_vld_r && (p_steps > scan_max_r)) begin
          scan_max_nxt = p_steps;
        end
        if (!issue && !p_vld_r) begin
          state_nxt = S_FIN;
          if (scan_max_r == '0) begin
            // No axis moves: the pending loads are thrown away.
            steps_vld_nxt = '0;
            dirs_nxt      = '0;
            dom_nxt       = '0;
            moving_nxt    = 1'b0;
            status_nxt    = ST_REJECT;
          end else begin
            dom_nxt     = scan_max_r;
            acc_vld_nxt = '0;
            tick_nxt    = '0;
            moving_nxt  = 1'b1;
            status_nxt  = ST_OK;
          end
        end
      end

      S_TICK: begin
        p_vld_nxt = issue;
        p_idx_nxt = rd_addr;
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        // Axes with a zero count are left alone; after a fault the words
        // still in flight are dropped.
        if (p_vld_r && !fault_r && (p_steps != '0)) begin
          am_we = 1'b1;
          acc_vld_nxt[p_idx_r] = 1'b1;
          if (p_ge) begin
            am_wdata = p_diff[ACC_W-1:0];
            if (p_block) begin
              fault_nxt = 1'b1;
            end else begin
              mask_nxt = mask_r | (LANE_W'(1) << p_slot);
            end
          end
        end
        if (!issue && !p_vld_r) begin
          state_nxt = S_FIN;
          if (fault_r) begin
            steps_vld_nxt = '0;
            dirs_nxt      = '0;
            dom_nxt       = '0;
            moving_nxt    = 1'b0;
            mask_nxt      = '0;
            status_nxt    = ST_FAULT;
          end else begin
            tick_nxt = tick_inc;
            if (tick_inc >= dom_r) begin
              steps_vld_nxt = '0;
              dirs_nxt      = '0;
              dom_nxt       = '0;
              moving_nxt    = 1'b0;
              status_nxt    = ST_FINISHED;
            end else begin
              status_nxt = ST_OK;
            end
          end
        end
      end

      S_FIN: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          o_status_nxt = status_r;
          o_mask_nxt   = mask_r;
          o_dir_nxt    = (cmd_r == CMD_TICK) ? tick_dirs_r : dirs_r;
          o_busy_nxt   = moving_r;
          o_steps_nxt  = tick_r;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      moving_r     <= 1'b0;
      dirs_r       <= '0;
      dom_r        <= '0;
      tick_r       <= '0;
      steps_vld_r  <= '0;
      acc_vld_r    <= '0;
      fault_r      <= 1'b0;
      cnt_r        <= '0;
      p_vld_r      <= 1'b0;
      out_vld_r    <= 1'b0;
      axis_count_r <= AXIS_COUNT_RST;
      min_en_r     <= '0;
      max_en_r     <= '0;
      pin_map_r    <= PIN_MAP_RST;
    end else begin
      state_r     <= state_nxt;
      moving_r    <= moving_nxt;
      dirs_r      <= dirs_nxt;
      dom_r       <= dom_nxt;
      tick_r      <= tick_nxt;
      steps_vld_r <= steps_vld_nxt;
      acc_vld_r   <= acc_vld_nxt;
      fault_r     <= fault_nxt;
      cnt_r       <= cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_AXIS_COUNT: axis_count_r <= cfg_wdata[ACNT_W-1:0];
          REG_MIN_ENABLE: min_en_r     <= cfg_wdata[LANE_W-1:0];
          REG_MAX_ENABLE: max_en_r     <= cfg_wdata[LANE_W-1:0];
          REG_PIN_MAP:    pin_map_r    <= cfg_wdata[MAP_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    tick_dirs_r <= tick_dirs_nxt;
    min_act_r   <= min_act_nxt;
    max_act_r   <= max_act_nxt;
    status_r    <= status_nxt;
    mask_r      <= mask_nxt;
    scan_max_r  <= scan_max_nxt;
    p_idx_r     <= p_idx_nxt;
    o_status_r  <= o_status_nxt;
    o_mask_r    <= o_mask_nxt;
    o_dir_r     <= o_dir_nxt;
    o_busy_r    <= o_busy_nxt;
    o_steps_r   <= o_steps_nxt;
  end

  // Step counts: written by a load, read during sweeps.
  always_ff @(posedge clk) begin
    if (sm_we) begin
      steps_mem[in_axis[AXIS_W-1:0]] <= in_steps;
    end
    steps_q <= steps_mem[rd_addr];
  end

  // Error accumulators: each axis is read once and written back at most once per
  // tick, so a read never meets a pending write to the same entry.
  always_ff @(posedge clk) begin
    if (am_we) begin
      acc_mem[p_idx_r] <= am_wdata;
    end
    acc_q <= acc_mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_dom_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (dom_r != '0))
    else $error("move in progress with a zero dominant count");

  a_tick_below_dom: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (tick_r < dom_r))
    else $error("tick counter reached the dominant count during a move");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(AXES))
    else $error("axis sweep ran past the axis count");

  a_fault_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (o_status_r == ST_FAULT)) |-> (o_mask_r == '0))
    else $error("step pulses sent on a limit fault");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new word accepted before the result of the last one");
`endif

endmodule
